@@ hdl/dq_pkg.sv @@
package dq_pkg;

    localparam int DATA_W  = 32;
    localparam int OP_W    = 3;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 9;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_CLEAR      = 3'd4,
        OP_QUERY      = 3'd5
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Per-cycle command that every cell of one chain sees.
    typedef struct packed {
        logic shift_up;
        logic shift_down;
        logic load;
    } t_cell_ctrl;

endpackage

@@ hdl/dq_in_if.sv @@
interface dq_in_if;
    import dq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          opcode;
    logic signed [DATA_W-1:0] push_value;

    modport source (output valid, output opcode, output push_value, input ready);
    modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

@@ hdl/dq_out_if.sv @@
interface dq_out_if;
    import dq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] popped_value;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
    logic [COUNT_W-1:0]       element_count;
    logic                     is_empty;

    modport source (output valid, output status, output popped_value, output front_value,
                    output back_value, output element_count, output is_empty, input ready);
    modport sink   (input valid, input status, input popped_value, input front_value,
                    input back_value, input element_count, input is_empty, output ready);
endinterface

@@ hdl/dq_cell.sv @@
module dq_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 9
) (
    input  logic                          i_clk,
    input  dq_pkg::t_cell_ctrl            i_ctrl,
    input  logic [CW-1:0]                 i_count,
    input  logic [dq_pkg::DATA_W-1:0]     i_lower,
    input  logic [dq_pkg::DATA_W-1:0]     i_upper,
    input  logic [dq_pkg::DATA_W-1:0]     i_push_value,
    output logic [dq_pkg::DATA_W-1:0]     o_data
);
    import dq_pkg::*;

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    logic              w_hit;

    assign w_hit = (i_count == CW'(INDEX));

    always_comb begin
        priority if (i_ctrl.shift_up) begin
            n_data = i_lower;
        end else if (i_ctrl.shift_down) begin
            n_data = i_upper;
        end else if (i_ctrl.load && w_hit) begin
            n_data = i_push_value;
        end else begin
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

@@ hdl/dq_chain.sv @@
module dq_chain #(
    parameter int DEPTH = 256,
    parameter int CW    = 9
) (
    input  logic                          i_clk,
    input  dq_pkg::t_cell_ctrl            i_ctrl,
    input  logic [CW-1:0]                 i_count,
    input  logic [dq_pkg::DATA_W-1:0]     i_push_value,
    output logic [dq_pkg::DATA_W-1:0]     o_head0,
    output logic [dq_pkg::DATA_W-1:0]     o_head1
);
    import dq_pkg::*;

    logic [DATA_W-1:0] w_data [DEPTH];

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [DATA_W-1:0] w_lower;
            logic [DATA_W-1:0] w_upper;

            // The head cell takes the new value on a shift toward the tail,
            // and the tail cell simply holds on a shift toward the head.
            if (g == 0) begin : g_head
                assign w_lower = i_push_value;
            end else begin : g_mid
                assign w_lower = w_data[g-1];
            end
            if (g == DEPTH - 1) begin : g_tail
                assign w_upper = w_data[g];
            end else begin : g_body
                assign w_upper = w_data[g+1];
            end

            dq_cell #(
                .INDEX (g),
                .CW    (CW)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (i_ctrl),
                .i_count      (i_count),
                .i_lower      (w_lower),
                .i_upper      (w_upper),
                .i_push_value (i_push_value),
                .o_data       (w_data[g])
            );
        end
    endgenerate

    assign o_head0 = w_data[0];
    assign o_head1 = w_data[1];

endmodule

@@ hdl/double_ended_queue_top.sv @@
// Channel  Direction  Payload
// i_in     sink       opcode[2:0], push_value[31:0] signed
// o_out    source     status[1:0], popped_value, front_value, back_value (32 bits signed),
//                     element_count[8:0], is_empty
//
// One transfer per cycle is sustained while o_out is ready, set by the single update of the
// two cell chains. The result is registered and appears in the cycle after the input
// transfer. Reset (synchronous, active low) empties the queue and the result register;
// cell contents are not cleared. The input is ready whenever the result register is empty
// or being taken, so a stall on o_out holds i_in off after one item.
module double_ended_queue_top #(
    parameter int DEPTH = 256
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    dq_in_if.sink   i_in,
    dq_out_if.source o_out
);
    import dq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    // Chain A keeps the front in cell 0, chain B keeps the back in cell 0.
    // Each holds the same elements in opposite order, so both ends sit at fixed cells.
    t_cell_ctrl        w_ctrl_a;
    t_cell_ctrl        w_ctrl_b;
    logic [DATA_W-1:0] w_a0, w_a1, w_b0, w_b1;

    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              r_out_valid;
    t_status           r_status;
    logic [DATA_W-1:0] r_popped;
    logic [DATA_W-1:0] r_front;
    logic [DATA_W-1:0] r_back;
    logic [COUNT_W-1:0] r_elem_count;
    logic              r_is_empty;

    t_status           w_status;
    logic [DATA_W-1:0] w_popped;
    logic [DATA_W-1:0] w_front;
    logic [DATA_W-1:0] w_back;
    logic [CW+COUNT_W-1:0] w_count_ext;

    logic    w_accept;
    logic    w_full;
    logic    w_empty;
    t_opcode w_op;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_op       = t_opcode'(i_in.opcode);

    always_comb begin
        w_ctrl_a = '0;
        w_ctrl_b = '0;
        n_count  = r_count;
        w_status = ST_OK;
        w_popped = '0;
        w_front  = w_a0;
        w_back   = w_b0;
        unique case (w_op)
            OP_PUSH_FRONT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctrl_a.shift_up = w_accept;
                    w_ctrl_b.load     = w_accept;
                    n_count           = r_count + 1'b1;
                    w_front           = i_in.push_value;
                    if (w_empty) begin
                        w_back = i_in.push_value;
                    end
                end
            end
            OP_PUSH_BACK: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctrl_b.shift_up = w_accept;
                    w_ctrl_a.load     = w_accept;
                    n_count           = r_count + 1'b1;
                    w_back            = i_in.push_value;
                    if (w_empty) begin
                        w_front = i_in.push_value;
                    end
                end
            end
            OP_POP_FRONT: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_ctrl_a.shift_down = w_accept;
                    n_count             = r_count - 1'b1;
                    w_popped            = w_a0;
                    w_front             = w_a1;
                end
            end
            OP_POP_BACK: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_ctrl_b.shift_down = w_accept;
                    n_count             = r_count - 1'b1;
                    w_popped            = w_b0;
                    w_back              = w_b1;
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
        if (n_count == '0) begin
            w_front = '0;
            w_back  = '0;
        end
    end

    // The count field carries the low bits of the count, zero-extended when narrower.
    assign w_count_ext = {{COUNT_W{1'b0}}, n_count};

    dq_chain #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_chain_a (
        .i_clk        (i_clk),
        .i_ctrl       (w_ctrl_a),
        .i_count      (r_count),
        .i_push_value (i_in.push_value),
        .o_head0      (w_a0),
        .o_head1      (w_a1)
    );

    dq_chain #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_chain_b (
        .i_clk        (i_clk),
        .i_ctrl       (w_ctrl_b),
        .i_count      (r_count),
        .i_push_value (i_in.push_value),
        .o_head0      (w_b0),
        .o_head1      (w_b1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status     <= w_status;
            r_popped     <= w_popped;
            r_front      <= w_front;
            r_back       <= w_back;
            r_elem_count <= w_count_ext[COUNT_W-1:0];
            r_is_empty   <= (n_count == '0);
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_status;
    assign o_out.popped_value  = r_popped;
    assign o_out.front_value   = r_front;
    assign o_out.back_value    = r_back;
    assign o_out.element_count = r_elem_count;
    assign o_out.is_empty      = r_is_empty;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("element count exceeds depth");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_op == OP_CLEAR) |=> (r_count == '0))
        else $error("clear left elements behind");

    a_full_push_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_full && (w_op == OP_PUSH_FRONT || w_op == OP_PUSH_BACK))
        |=> (r_count == CW'(DEPTH)) && (r_status == ST_FULL))
        else $error("push into a full queue changed the count");

    a_empty_pop_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_empty && (w_op == OP_POP_FRONT || w_op == OP_POP_BACK))
        |=> (r_count == '0) && (r_status == ST_EMPTY) && (r_popped == '0))
        else $error("pop from an empty queue misbehaved");

    a_empty_values_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_is_empty) |-> (r_front == '0) && (r_back == '0))
        else $error("end values not zero on an empty queue");

endmodule
